FILE: hw/rtl/point_deque_with_indexed_write_macros.svh
// Assertion macros for the file that checks its own behavior.
`ifndef POINT_DEQUE_WITH_INDEXED_WRITE_MACROS_SVH
`define POINT_DEQUE_WITH_INDEXED_WRITE_MACROS_SVH
`ifndef SYNTHESIS
// Checks that cons holds in the same cycle as ante.
`define PDQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Checks that cons holds in the cycle after ante.
`define PDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PDQ_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define PDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/pdq_pkg.sv
package pdq_pkg;

    localparam int DEPTH  = 64;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = 7;

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SET        = 3'd4,
        FN_DUMP       = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic exec;
        logic dump_start;
        logic dump_rd;
        logic dump_load;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic out_last;
    } t_stat;

    // Ring slot that lies off places behind base; off stays below DEPTH.
    function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] base,
                                                   logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

    // Ring slot just ahead of base.
    function automatic logic [SLOT_W-1:0] slot_dec(logic [SLOT_W-1:0] base);
        logic [SLOT_W-1:0] res;
        if (base == '0) begin
            res = SLOT_W'(DEPTH - 1);
        end else begin
            res = base - SLOT_W'(1);
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/pdq_datapath.sv
module pdq_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pdq_pkg::t_cmd            i_cmd,
    output pdq_pkg::t_stat           o_stat,
    input  logic [2:0]               i_func,
    input  logic signed [15:0]       i_point_x,
    input  logic signed [15:0]       i_point_y,
    input  logic [6:0]               i_position,
    output logic [1:0]               o_status,
    output logic [6:0]               o_entry_count,
    output logic signed [15:0]       o_out_x,
    output logic signed [15:0]       o_out_y,
    output logic                     o_last
);
    import pdq_pkg::*;

    logic [31:0]       r_mem [DEPTH];
    logic [31:0]       r_rdata;
    logic [SLOT_W-1:0] r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_idx;
    logic [1:0]        r_status;
    logic [CNT_W-1:0]  r_out_count;
    logic [15:0]       r_out_x, r_out_y;
    logic              r_last;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] rd_addr;
    logic [31:0]       wdata;
    t_status           ex_status;
    logic              full, empty, idx_last;

    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign wdata    = {i_point_x, i_point_y};
    assign rd_addr  = slot_add(r_front, CNT_W'(r_idx));
    assign idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // Effect of one non-dump request on the ring pointers and the store.
    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        wr_en     = 1'b0;
        wr_addr   = r_front;
        ex_status = ST_OK;
        case (t_func'(i_func))
            FN_PUSH_FRONT: begin
                if (full) begin
                    ex_status = ST_FULL;
                end else begin
                    n_front = slot_dec(r_front);
                    wr_addr = slot_dec(r_front);
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            FN_PUSH_BACK: begin
                if (full) begin
                    ex_status = ST_FULL;
                end else begin
                    wr_addr = slot_add(r_front, r_count);
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            FN_POP_FRONT: begin
                if (empty) begin
                    ex_status = ST_EMPTY;
                end else begin
                    n_front = slot_add(r_front, CNT_W'(1));
                    n_count = r_count - CNT_W'(1);
                end
            end
            FN_POP_BACK: begin
                if (empty) begin
                    ex_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            FN_SET: begin
                if (empty) begin
                    ex_status = ST_EMPTY;
                end else if (i_position >= r_count) begin
                    ex_status = ST_RANGE;
                end else begin
                    wr_addr = slot_add(r_front, i_position);
                    wr_en   = 1'b1;
                end
            end
            FN_DUMP: begin
                if (empty) begin
                    ex_status = ST_EMPTY;
                end
            end
            default: begin
                ex_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (i_cmd.dump_start) begin
                r_idx <= '0;
            end else if (i_cmd.dump_load) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= wdata;
        end
        if (i_cmd.dump_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= ex_status;
            r_out_count <= n_count;
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_last      <= 1'b1;
        end else if (i_cmd.dump_load) begin
            r_status    <= ST_OK;
            r_out_count <= r_count;
            r_out_x     <= r_rdata[31:16];
            r_out_y     <= r_rdata[15:0];
            r_last      <= idx_last;
        end
    end

    assign o_stat.empty    = empty;
    assign o_stat.out_last = r_last;
    assign o_status        = r_status;
    assign o_entry_count   = r_out_count;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_last          = r_last;

endmodule

FILE: hw/rtl/pdq_ctrl.sv
module pdq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [2:0]     i_func,
    output logic           o_valid,
    input  logic           i_stall,
    input  pdq_pkg::t_stat i_stat,
    output pdq_pkg::t_cmd  o_cmd
);
    import pdq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LOAD = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_take, in_take, is_dump;

    assign out_take = r_valid && !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && (!r_valid || !i_stall));
    assign in_take  = i_valid && !o_stall;
    assign is_dump  = (t_func'(i_func) == FN_DUMP) && !i_stat.empty;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (out_take) begin
                    n_valid = 1'b0;
                end
                if (in_take) begin
                    if (is_dump) begin
                        o_cmd.dump_start = 1'b1;
                        n_state          = S_READ;
                    end else begin
                        o_cmd.exec = 1'b1;
                        n_valid    = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.dump_rd = 1'b1;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.dump_load = 1'b1;
                n_valid         = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (out_take) begin
                    n_valid = 1'b0;
                    n_state = i_stat.out_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;

endmodule

FILE: hw/rtl/point_deque_with_indexed_write.sv
// Push, pop, set, an unknown code and a dump of an empty list: one result word, valid in
// the cycle after accept; a new word is taken each cycle while the result side keeps pace.
// Dump: each point goes through a memory read, an output load and a handoff, as the point
// store has a single registered read port; the input is stalled until the last word leaves.
// Reset (synchronous, active low) empties the list and clears the output valid;
// the point store itself is not cleared.
`include "point_deque_with_indexed_write_macros.svh"

module point_deque_with_indexed_write (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic [6:0]         i_position,
    // Result channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [6:0]         o_entry_count,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic               o_last
);
    import pdq_pkg::*;

    // The controller sequences requests and dumps; the datapath owns the ring
    // store, the front pointer, the count and the registered result word.
    t_cmd  cmd;
    t_stat stat;

    pdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_func  (i_func),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pdq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_func),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_position    (i_position),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_last        (o_last)
    );

    // A result word that is held back must keep the request side closed.
    `PDQ_ASSERT_SAME(a_hold_blocks_input, i_clk, i_rst_n, o_valid && i_stall, o_stall)
    // The reported count never passes the ring capacity.
    `PDQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_valid, o_entry_count <= 7'(DEPTH))
    // Every word of a dump but the final one is a stored point with ok status.
    `PDQ_ASSERT_SAME(a_dump_ok, i_clk, i_rst_n, o_valid && !o_last, o_status == ST_OK)
    // Once a middle dump word leaves, the dump continues and input stays closed.
    `PDQ_ASSERT_NEXT(a_dump_continues, i_clk, i_rst_n, o_valid && !i_stall && !o_last,
                     o_stall)

endmodule

FILE: test/point_deque_with_indexed_write_tb.sv
`timescale 1ns / 1ps

module point_deque_with_indexed_write_tb;

    import pdq_pkg::*;

    // The two function codes that the block leaves unused. It must still answer
    // each of them with a single word.
    localparam logic [2:0] FN_RESERVED_6 = 3'd6;
    localparam logic [2:0] FN_RESERVED_7 = 3'd7;

    localparam logic [6:0] POS_MAX      = 7'h7F;
    localparam int         RANDOM_ITEMS = 120;
    localparam int         SETTLE_TIME  = 16;
    // The limit is several times the slowest correct run. That run assumes every request
    // is a full dump and every word meets the longest stall.
    localparam int         CYCLE_LIMIT  = 4_000_000;

    // One result word, as the block should present it.
    typedef struct {
        t_status                st;
        logic [CNT_W-1:0]       count;
        logic signed [15:0]     x;
        logic signed [15:0]     y;
        logic                   last;
    } t_deque_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_func;
    logic signed [15:0] i_point_x;
    logic signed [15:0] i_point_y;
    logic [6:0]         i_position;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_status;
    logic [6:0]         o_entry_count;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic               o_last;

    point_deque_with_indexed_write dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_last        (o_last)
    );

    // The testbench keeps its own copy of the ring: the slots, the slot of the
    // front point and the number of points held. The copy moves forward at the
    // clock edge where each request word is taken.
    logic [31:0]  ring_store [DEPTH];
    int           ring_front;
    int           ring_count;

    // These are the words the block still owes, oldest first.
    t_deque_word  words_due [$];

    int           fail_count;
    int           cycle_count;

    // Sender idling. The gaps can be switched off. A quiet run gives a stretch
    // of back-to-back words.
    bit           tx_gaps_on;
    int           tx_quiet_left;

    // While this count is above zero, the result side holds i_stall high and counts it down.
    int           rx_hold_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Works out the words that one request causes and updates the ring copy.
    // Push, pop, set, the unused codes and a dump of an empty list give one word with zero coordinates.
    // A dump of a non-empty list gives one word per point, from the front to the back.
    function automatic void run_deque_request(input logic [2:0]         func,
                                              input logic signed [15:0] px,
                                              input logic signed [15:0] py,
                                              input logic [6:0]         pos);
        t_status    st;
        logic [31:0] pt;
        st = ST_OK;
        case (func)
            FN_PUSH_FRONT: begin
                if (ring_count >= DEPTH) begin
                    st = ST_FULL;
                end else begin
                    ring_front = (ring_front + DEPTH - 1) % DEPTH;
                    ring_store[ring_front] = {px, py};
                    ring_count++;
                end
            end
            FN_PUSH_BACK: begin
                if (ring_count >= DEPTH) begin
                    st = ST_FULL;
                end else begin
                    ring_store[(ring_front + ring_count) % DEPTH] = {px, py};
                    ring_count++;
                end
            end
            FN_POP_FRONT: begin
                if (ring_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    ring_front = (ring_front + 1) % DEPTH;
                    ring_count--;
                end
            end
            FN_POP_BACK: begin
                if (ring_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    ring_count--;
                end
            end
            FN_SET: begin
                // An empty list is reported before the index is looked at.
                if (ring_count == 0) begin
                    st = ST_EMPTY;
                end else if (int'(pos) >= ring_count) begin
                    st = ST_RANGE;
                end else begin
                    ring_store[(ring_front + int'(pos)) % DEPTH] = {px, py};
                end
            end
            FN_DUMP: begin
                if (ring_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    for (int k = 0; k < ring_count; k++) begin
                        pt = ring_store[(ring_front + k) % DEPTH];
                        words_due.push_back('{ST_OK, CNT_W'(ring_count), pt[31:16],
                                              pt[15:0], k == ring_count - 1});
                    end
                    return;
                end
            end
            default: ;
        endcase
        words_due.push_back('{st, CNT_W'(ring_count), 16'sd0, 16'sd0, 1'b1});
    endfunction

    // Most idle stretches are short. A few are long.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic int pick_send_gap();
        if (!tx_gaps_on) return 0;
        if (tx_quiet_left > 0) begin
            tx_quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            tx_quiet_left = $urandom_range(10, 30);
            return 0;
        end
        if ($urandom_range(0, 1) == 0) return 0;
        return pick_idle_len();
    endfunction

    // Coordinates hit the extremes, zero and minus one now and then. Otherwise
    // they are uniform over all 16 bits.
    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one request word. The task drives at a falling edge and waits for
    // the rising edge that takes the word. It leaves i_valid high, so the next
    // call can either drive new data at once or lower valid for a gap.
    task automatic send_word(input logic [2:0]         func,
                             input logic signed [15:0] px,
                             input logic signed [15:0] py,
                             input logic [6:0]         pos);
        int gap;
        gap = pick_send_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= func;
        i_point_x  <= px;
        i_point_y  <= py;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
        run_deque_request(func, px, py, pos);
    endtask

    task automatic send_random_payload(input logic [2:0] func);
        send_word(func, rand_coord(), rand_coord(), 7'($urandom_range(0, 127)));
    endtask

    // Stops offering words and waits until every word that is owed has come back.
    task automatic wait_words_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_field(input string              name,
                                 input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // The result side takes a word at each rising edge where o_valid is high and
    // i_stall is low. Every word taken is checked against the oldest word owed.
    always @(posedge i_clk) begin : check_result_words
        t_deque_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (words_due.size() == 0) begin
                $error("result word arrived while none was owed");
                fail_count++;
            end else begin
                want = words_due.pop_front();
                compare_field("status", 32'(want.st), 32'(o_status));
                compare_field("entry_count", 32'(want.count), 32'(o_entry_count));
                compare_field("out_x", 32'(want.x), 32'(o_out_x));
                compare_field("out_y", 32'(want.y), 32'(o_out_y));
                compare_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // Stall on the result side. Runs with no stall alternate with stall bursts
    // of random length. A requested hold overrides both.
    initial begin : result_stall
        int  run_left;
        logic holding;
        i_stall  = 1'b0;
        run_left = 0;
        holding  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_stall <= 1'b1;
                rx_hold_left--;
            end else begin
                if (run_left == 0) begin
                    holding  = !holding;
                    run_left = holding ? pick_idle_len() : $urandom_range(1, 40);
                end
                i_stall <= holding;
                run_left--;
            end
        end
    end

    // Each request but a push on an empty list: pops, a set at both ends of the index
    // range, a dump that gives its single empty word, and both unused codes.
    task automatic test_empty_list();
        send_random_payload(FN_DUMP);
        send_random_payload(FN_POP_FRONT);
        send_random_payload(FN_POP_BACK);
        send_word(FN_SET, 16'sh1234, -16'sh1234, 7'd0);
        send_word(FN_SET, 16'sh7FFF, 16'sh8000, POS_MAX);
        send_random_payload(FN_RESERVED_6);
        send_random_payload(FN_RESERVED_7);
    endtask

    // Pushes at both ends with extreme coordinates, then sets at the first and the last index
    // and just past the end, then a dump, pops from both ends, an unused code and a second dump.
    task automatic test_basic_ops();
        send_word(FN_PUSH_FRONT, 16'sh7FFF, 16'sh8000, POS_MAX);
        send_word(FN_PUSH_BACK, 16'sh8000, 16'sh7FFF, 7'd0);
        send_word(FN_PUSH_FRONT, 16'sh0000, 16'shFFFF, 7'd0);
        send_word(FN_PUSH_BACK, 16'shFFFF, 16'sh0000, POS_MAX);
        send_word(FN_SET, 16'sh5A5A, -16'sh5A5A, 7'd0);
        send_word(FN_SET, -16'sh0001, 16'sh0001, 7'd3);
        send_word(FN_SET, 16'sh0BAD, 16'sh0BAD, 7'd4);
        send_word(FN_SET, 16'sh0BAD, 16'sh0BAD, POS_MAX);
        send_random_payload(FN_DUMP);
        send_random_payload(FN_POP_FRONT);
        send_random_payload(FN_POP_BACK);
        send_random_payload(FN_RESERVED_6);
        send_random_payload(FN_DUMP);
    endtask

    // The result side holds off for a long stretch while the sender keeps
    // offering pushes back to back. The block's output fills up and it must
    // stall its input without losing or repeating a word.
    task automatic test_output_hold_off();
        tx_gaps_on   = 1'b0;
        rx_hold_left = 300;
        for (int n = 0; n < 24; n++) begin
            send_random_payload(n % 3 == 0 ? FN_PUSH_FRONT : FN_PUSH_BACK);
        end
        send_random_payload(FN_DUMP);
        tx_gaps_on = 1'b1;
    endtask

    // Fills the ring to capacity and checks every case at the full mark. It
    // then empties the ring again from both ends.
    task automatic test_full_list();
        while (ring_count < DEPTH) begin
            send_random_payload($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT);
        end
        send_random_payload(FN_PUSH_FRONT);
        send_random_payload(FN_PUSH_BACK);
        send_word(FN_SET, 16'sh7FFF, 16'sh7FFF, 7'(DEPTH - 1));
        send_word(FN_SET, 16'sh8000, 16'sh8000, 7'(DEPTH));
        send_word(FN_SET, 16'sh8000, 16'sh8000, POS_MAX);
        send_random_payload(FN_DUMP);
        while (ring_count > 0) begin
            send_random_payload($urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT);
        end
        send_random_payload(FN_POP_BACK);
    endtask

    // A random mix of requests. The bias swings between growing and shrinking
    // the list, so the run passes through the empty state and through a range of
    // fill levels. Most set requests use an index inside the list.
    task automatic test_random_mix();
        logic [2:0] func;
        logic [6:0] pos;
        int         r;
        bit         grow;
        grow = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 45 == 44) grow = !grow;
            r = $urandom_range(0, 99);
            if (r < (grow ? 50 : 20)) begin
                func = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            end else if (r < 70) begin
                func = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
            end else if (r < 86) begin
                func = FN_SET;
            end else if (r < 96) begin
                func = FN_DUMP;
            end else begin
                func = $urandom_range(0, 1) ? FN_RESERVED_7 : FN_RESERVED_6;
            end
            if (ring_count > 0 && $urandom_range(0, 3) != 0) begin
                pos = 7'($urandom_range(0, ring_count - 1));
            end else begin
                pos = 7'($urandom_range(0, 127));
            end
            send_word(func, rand_coord(), rand_coord(), pos);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_func        = FN_PUSH_FRONT;
        i_point_x     = '0;
        i_point_y     = '0;
        i_position    = '0;
        ring_front    = 0;
        ring_count    = 0;
        fail_count    = 0;
        cycle_count   = 0;
        tx_gaps_on    = 1'b1;
        tx_quiet_left = 0;
        rx_hold_left  = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Between tests, the sender waits until every owed word has come back.
        test_empty_list();
        wait_words_drained();
        test_basic_ops();
        wait_words_drained();
        test_output_hold_off();
        wait_words_drained();
        test_full_list();
        wait_words_drained();
        test_random_mix();
        wait_words_drained();

        // Any stray word after the last owed one is caught by the result checker.
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pdq_pkg.sv
hw/rtl/pdq_datapath.sv
hw/rtl/pdq_ctrl.sv
hw/rtl/point_deque_with_indexed_write.sv
test/point_deque_with_indexed_write_tb.sv
